>>> rtl/ffc_pkg.sv
// ----------------------------------------------------------------------------
// ffc_pkg
// Shared constants and types of the flat field calibration block.
// ----------------------------------------------------------------------------
package ffc_pkg;

  localparam int unsigned MaxPixels = 262144;
  localparam int unsigned MaxFrames = 64;

  localparam int unsigned IdxW   = 18;
  localparam int unsigned RawW   = 16;
  localparam int unsigned SumW   = 22;
  localparam int unsigned FrmW   = 7;
  localparam int unsigned OutW   = 20;
  localparam int unsigned ProdW  = 29;   // 22 + 7
  localparam int unsigned NumW   = 36;   // needs 31 of the 37 signed bits
  localparam int unsigned DivW   = 52;   // numerator magnitude shifted by 16
  localparam int unsigned DenW   = 30;   // denominator magnitude

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [OutW-1:0] OutMax = {OutW{1'b1}};

  localparam logic [FrmW-1:0] DarkFramesRst = 7'd30;
  localparam logic [FrmW-1:0] RespFramesRst = 7'd25;

  typedef enum logic [1:0] {
    ModeDark    = 2'd0,
    ModeResp    = 2'd1,
    ModeCorrect = 2'd2,
    ModeNone    = 2'd3
  } mode_e;

  typedef enum logic {
    RegDarkFrames = 1'b0,
    RegRespFrames = 1'b1
  } reg_e;

  // Quotient pipeline payload passed between the divider stages.
  typedef struct packed {
    logic            vld;
    logic [IdxW-1:0] idx;
    logic            force_sat;
    logic            force_zero;
  } ffc_tag_t;

endpackage

>>> rtl/ffc_ram.sv
// ----------------------------------------------------------------------------
// ffc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/ffc_div.sv
// ----------------------------------------------------------------------------
// ffc_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module ffc_div
  import ffc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  ffc_tag_t              tag_i,
  input  logic [DivW-1:0]       num_i,
  input  logic [DenW-1:0]       den_i,
  output ffc_tag_t              tag_o,
  output logic [OutW-1:0]       quo_o,
  output logic                  sat_o
);

  // A quotient above OutMax saturates: the top DivW-OutW bits only need to be
  // compared with den. Pre-check num >= den << OutW, then do OutW bit steps.
  localparam int unsigned Steps = OutW;
  localparam int unsigned RemW  = DenW + 1;

  ffc_tag_t           tag_q  [Steps+1];
  logic [RemW-1:0]    rem_q  [Steps+1];
  logic [OutW-1:0]    low_q  [Steps+1];
  logic [OutW-1:0]    quo_q  [Steps+1];
  logic [DenW-1:0]    den_q  [Steps+1];
  logic               ovf_q  [Steps+1];

  logic [RemW-1:0]    sh     [Steps];
  logic [RemW-1:0]    df     [Steps];

  logic [DivW-OutW-1:0] hi_num;
  assign hi_num = num_i[DivW-1:OutW];

  always_comb begin
    for (int s = 0; s < Steps; s++) begin
      sh[s] = {rem_q[s][RemW-2:0], low_q[s][OutW-1]};
      df[s] = sh[s] - {1'b0, den_q[s]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= Steps; s++) begin
        tag_q[s] <= '0;
      end
    end else if (en_i) begin
      tag_q[0] <= tag_i;
      for (int s = 0; s < Steps; s++) begin
        tag_q[s+1] <= tag_q[s];
      end
    end
  end

  // Stage 0: overflow check on the high part, start remainder; then bit steps.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= (hi_num >= {{(DivW-OutW-DenW){1'b0}}, den_i});
      rem_q[0] <= {1'b0, hi_num[DenW-1:0]};
      low_q[0] <= num_i[OutW-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      for (int s = 0; s < Steps; s++) begin
        ovf_q[s+1] <= ovf_q[s];
        den_q[s+1] <= den_q[s];
        low_q[s+1] <= {low_q[s][OutW-2:0], 1'b0};
        quo_q[s+1] <= {quo_q[s][OutW-2:0], ~df[s][RemW-1]};
        rem_q[s+1] <= df[s][RemW-1] ? sh[s] : df[s];
      end
    end
  end

  always_comb begin
    tag_o = tag_q[Steps];
    sat_o = 1'b0;
    quo_o = quo_q[Steps];
    priority if (tag_q[Steps].force_zero) begin
      quo_o = '0;
    end else if (tag_q[Steps].force_sat || ovf_q[Steps]) begin
      quo_o = OutMax;
      sat_o = 1'b1;
    end
  end

endmodule

>>> rtl/flat_field_calibration.sv
// ----------------------------------------------------------------------------
// flat_field_calibration
// Per-pixel dark and response calibration with a pipelined divider.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while in_stall_o is low; accumulate and
//   correct items mix freely. A correct item passes the RAM read, the product
//   stage, the numerator stage, 21 divider stages and the output register.
// Reset: control clears at once, then a clearing pass over all MAX_PIXELS
//   entries zeroes both sum memories; in_stall_o stays high during the pass.
module flat_field_calibration
  import ffc_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = MaxPixels
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic [IdxW-1:0]   pixel_index_i,
  input  logic [RawW-1:0]   raw_pixel_i,
  input  logic              first_frame_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IdxW-1:0]   pixel_out_index_o,
  output logic [OutW-1:0]   corrected_o,
  output logic              saturated_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned AddrW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CntW  = AddrW + 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [FrmW-1:0] nd_q, nr_q;
  logic            cfg_wr;
  reg_e            cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & (paddr[1:0] == 2'b00) & (paddr[2] == 1'b0 ||
                   paddr[2] == 1'b1);
  assign cfg_sel = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_q <= DarkFramesRst;
      nr_q <= RespFramesRst;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        RegDarkFrames: nd_q <= pwdata[FrmW-1:0];
        RegRespFrames: nr_q <= pwdata[FrmW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      RegDarkFrames: prdata = {{(32-FrmW){1'b0}}, nd_q};
      RegRespFrames: prdata = {{(32-FrmW){1'b0}}, nr_q};
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Global advance: the whole pipe moves when the output slot is free. A
  // skid-free design: the pipe holds in place under output stall, so the input
  // stalls only when the output register is full and stalled, or while clearing.
  // --------------------------------------------------------------------------
  logic       out_vld_q;
  logic       adv;
  logic       clr_busy_q;
  logic [CntW-1:0] clr_cnt_q;

  assign adv        = !(out_vld_q && out_stall_i);
  assign in_stall_o = !adv || clr_busy_q;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == CntW'(MAX_PIXELS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: accept, read both memories.
  // --------------------------------------------------------------------------
  logic in_range;
  assign in_range = ({2'b00, pixel_index_i} < 20'(MAX_PIXELS));

  logic [AddrW-1:0] rd_addr;
  assign rd_addr = pixel_index_i[AddrW-1:0];

  // Stage 1 registers
  logic              s1_vld_q;
  mode_e             s1_mode_q;
  logic [IdxW-1:0]   s1_idx_q;
  logic [RawW-1:0]   s1_raw_q;
  logic              s1_first_q;
  logic              s1_inr_q;
  logic [SumW-1:0]   d_rd, r_rd;

  // Write-back stage registers (stage 2 holds the write just issued)
  logic              wb_vld_q;
  logic              wb_dark_q;
  logic [AddrW-1:0]  wb_addr_q;
  logic [SumW-1:0]   wb_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mode_q  <= mode_e'(mode_i);
      s1_idx_q   <= pixel_index_i;
      s1_raw_q   <= raw_pixel_i;
      s1_first_q <= first_frame_i;
      s1_inr_q   <= in_range;
    end
  end

  // Memory read happens while stalled too; keep the read address steady.
  logic [AddrW-1:0] ram_raddr;
  assign ram_raddr = adv ? rd_addr : s1_idx_q[AddrW-1:0];

  // Forward the write of the previous item when it hits the same entry.
  logic [SumW-1:0] d_cur, r_cur;
  logic            fwd_hit;
  assign fwd_hit = wb_vld_q && (wb_addr_q == s1_idx_q[AddrW-1:0]);

  always_comb begin
    d_cur = d_rd;
    r_cur = r_rd;
    if (fwd_hit && wb_dark_q)  d_cur = wb_data_q;
    if (fwd_hit && !wb_dark_q) r_cur = wb_data_q;
  end

  // Read-modify-write in stage 1
  logic [SumW:0]   sum_add;
  logic [SumW-1:0] new_sum;
  logic            wr_en;
  logic            wr_dark;
  always_comb begin
    sum_add = {1'b0, s1_mode_q == ModeDark ? d_cur : r_cur} + (SumW+1)'(s1_raw_q);
    new_sum = s1_first_q ? SumW'(s1_raw_q) : (sum_add[SumW] ? SumMax : sum_add[SumW-1:0]);
    wr_dark = (s1_mode_q == ModeDark);
    wr_en   = adv && s1_vld_q && s1_inr_q &&
              (s1_mode_q == ModeDark || s1_mode_q == ModeResp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_vld_q <= 1'b0;
    end else if (adv) begin
      wb_vld_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wb_dark_q <= wr_dark;
      wb_addr_q <= s1_idx_q[AddrW-1:0];
      wb_data_q <= new_sum;
    end
  end

  logic             dm_we, rm_we;
  logic [AddrW-1:0] m_waddr;
  logic [SumW-1:0]  m_wdata;
  assign dm_we   = clr_busy_q || (wr_en && wr_dark);
  assign rm_we   = clr_busy_q || (wr_en && !wr_dark);
  assign m_waddr = clr_busy_q ? clr_cnt_q[AddrW-1:0] : s1_idx_q[AddrW-1:0];
  assign m_wdata = clr_busy_q ? '0 : new_sum;

  ffc_ram #(.Width(SumW), .Depth(MAX_PIXELS)) u_dark_ram (
    .clk_i, .we_i(dm_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(ram_raddr), .rdata_o(d_rd)
  );

  ffc_ram #(.Width(SumW), .Depth(MAX_PIXELS)) u_resp_ram (
    .clk_i, .we_i(rm_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(ram_raddr), .rdata_o(r_rd)
  );

  // --------------------------------------------------------------------------
  // Stage 2: products raw*Nd, Nd*R, Nr*D.
  // --------------------------------------------------------------------------
  logic                 s2_vld_q;
  logic [IdxW-1:0]      s2_idx_q;
  logic [RawW+FrmW-1:0] s2_rawnd_q;
  logic [SumW-1:0]      s2_d_q;
  logic [ProdW-1:0]     s2_ndr_q, s2_nrd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q && (s1_mode_q == ModeCorrect);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_idx_q   <= s1_idx_q;
      s2_rawnd_q <= s1_raw_q * nd_q;
      s2_d_q     <= s1_inr_q ? d_cur : '0;
      s2_ndr_q   <= nd_q * (s1_inr_q ? r_cur : SumW'(0));
      s2_nrd_q   <= nr_q * (s1_inr_q ? d_cur : SumW'(0));
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: numerator Nr*(raw*Nd - D), denominator difference.
  // --------------------------------------------------------------------------
  logic                    s3_vld_q;
  logic [IdxW-1:0]         s3_idx_q;
  logic signed [NumW:0]    s3_num_q;
  logic signed [ProdW:0]   s3_den_q;
  logic signed [SumW+2:0]  diff;
  assign diff = $signed({2'b00, s2_rawnd_q}) - $signed({3'b000, s2_d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_idx_q <= s2_idx_q;
      s3_num_q <= (NumW+1)'(diff * $signed({1'b0, nr_q}));
      s3_den_q <= $signed({1'b0, s2_ndr_q}) - $signed({1'b0, s2_nrd_q});
    end
  end

  // Sign handling, magnitudes into the divider.
  ffc_tag_t        dtag;
  logic [DivW-1:0] dnum;
  logic [DenW-1:0] dden;
  logic [NumW:0]   an;
  logic [ProdW:0]  ad;
  logic            num_pos, num_neg, den_pos, den_zero;
  always_comb begin
    num_pos  = !s3_num_q[NumW] && (s3_num_q != '0);
    num_neg  = s3_num_q[NumW];
    den_zero = (s3_den_q == '0);
    den_pos  = !s3_den_q[ProdW] && !den_zero;
    an       = num_neg ? (NumW+1)'(-s3_num_q) : s3_num_q;
    ad       = s3_den_q[ProdW] ? (ProdW+1)'(-s3_den_q) : s3_den_q;
    dnum     = DivW'({an, 16'h0000});
    dden     = den_zero ? DenW'(1) : DenW'(ad);
    dtag.vld        = s3_vld_q;
    dtag.idx        = s3_idx_q;
    dtag.force_sat  = den_zero && num_pos;
    dtag.force_zero = den_zero ? !num_pos : !((num_pos && den_pos) || (num_neg && !den_pos));
  end

  ffc_tag_t        qtag;
  logic [OutW-1:0] quo;
  logic            qsat;

  ffc_div u_div (
    .clk_i, .rst_ni, .en_i(adv),
    .tag_i(dtag), .num_i(dnum), .den_i(dden),
    .tag_o(qtag), .quo_o(quo), .sat_o(qsat)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [IdxW-1:0] out_idx_q;
  logic [OutW-1:0] out_corr_q;
  logic            out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= qtag.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_idx_q  <= qtag.idx;
      out_corr_q <= quo;
      out_sat_q  <= qsat;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign pixel_out_index_o = out_idx_q;
  assign corrected_o       = out_corr_q;
  assign saturated_o       = out_sat_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_acc_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_acc) else $error("accepted during clearing pass");

  a_sat_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> corrected_o == OutMax) else $error("sat without max");

  a_no_wr_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv && !clr_busy_q |-> !dm_we && !rm_we) else $error("write during stall");

endmodule

>>> tb/sv/tb_flat_field_calibration.sv
// ----------------------------------------------------------------------------
// tb_flat_field_calibration
// Drives raw pixels in dark, response, correct and none mode through the block,
// rewrites the frame counts between phases and checks each corrected pixel
// against a cycle-free model of the stores and quotient, or typed results.
// ----------------------------------------------------------------------------
module tb_flat_field_calibration
  import ffc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned PhaseItems  = 75;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [OutW-1:0] corr;
    logic            sat;
  } pixel_result_t;

  typedef struct {
    mode_e           mode;
    logic [IdxW-1:0] idx;
    logic [RawW-1:0] raw;
    logic            first;
    bit              typed;     // expected result written out below
    logic [OutW-1:0] corr;
    logic            sat;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] mode_i = '0;
  logic [IdxW-1:0] pixel_index_i = '0;
  logic [RawW-1:0] raw_pixel_i = '0;
  logic first_frame_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [IdxW-1:0] pixel_out_index_o;
  logic [OutW-1:0] corrected_o;
  logic saturated_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  flat_field_calibration u_top (.*);

  always #5 clk_i = ~clk_i;

  // Model state: per-pixel sums (absent entries are zero) and frame counts.
  logic [SumW-1:0] dark_sums [logic [IdxW-1:0]];
  logic [SumW-1:0] resp_sums [logic [IdxW-1:0]];
  logic [FrmW-1:0] dark_frames_m = DarkFramesRst;
  logic [FrmW-1:0] resp_frames_m = RespFramesRst;

  pixel_result_t pending_pixels[$];
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   hold_cycles = 0;   // request for a long receiver hold-off
  logic [IdxW-1:0] pixel_pool[8];

  // Quotient Nr*(raw*Nd - D) / (Nd*R - Nr*D) in Q4.16, clamped and saturated.
  function automatic pixel_result_t calibrate_pixel(logic [IdxW-1:0] idx,
                                                    logic [RawW-1:0] raw);
    longint d, r, nd, nr, num, den;
    longint unsigned an, ad, q;
    pixel_result_t res;
    d = dark_sums.exists(idx) ? longint'(dark_sums[idx]) : 0;
    r = resp_sums.exists(idx) ? longint'(resp_sums[idx]) : 0;
    nd = longint'(dark_frames_m);
    nr = longint'(resp_frames_m);
    num = nr * (longint'(raw) * nd - d);
    den = nd * r - nr * d;
    res.idx = idx;
    res.corr = '0;
    res.sat = 1'b0;
    if (den == 0) begin
      if (num > 0) begin
        res.corr = OutMax;
        res.sat = 1'b1;
      end
    end else if ((num > 0 && den > 0) || (num < 0 && den < 0)) begin
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      q = (an << 16) / ad;
      if (q > longint'(OutMax)) begin
        res.corr = OutMax;
        res.sat = 1'b1;
      end else begin
        res.corr = q[OutW-1:0];
      end
    end
    return res;
  endfunction

  // Add a sample into a sum, saturating at the sum width; first restarts it.
  function automatic logic [SumW-1:0] add_sample(logic [SumW-1:0] sum,
                                                 logic [RawW-1:0] raw, logic first);
    logic [SumW:0] s;
    if (first) return SumW'(raw);
    s = sum + raw;
    return (s > SumMax) ? SumMax : s[SumW-1:0];
  endfunction

  // Advance the model by one accepted transaction; queue a result if any.
  task automatic model_pixel(mode_e mode, logic [IdxW-1:0] idx, logic [RawW-1:0] raw,
                             logic first, bit typed, pixel_result_t typed_res);
    logic [SumW-1:0] old;
    case (mode)
      ModeDark: begin
        old = dark_sums.exists(idx) ? dark_sums[idx] : '0;
        dark_sums[idx] = add_sample(old, raw, first);
      end
      ModeResp: begin
        old = resp_sums.exists(idx) ? resp_sums[idx] : '0;
        resp_sums[idx] = add_sample(old, raw, first);
      end
      ModeCorrect: begin
        pending_pixels.push_back(typed ? typed_res : calibrate_pixel(idx, raw));
      end
      default: ;
    endcase
  endtask

  // Offer one transaction and hold it until the block takes it.
  task automatic send_pixel(mode_e mode, logic [IdxW-1:0] idx, logic [RawW-1:0] raw,
                            logic first, bit typed = 1'b0,
                            pixel_result_t typed_res = '0);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    mode_i = mode;
    pixel_index_i = idx;
    raw_pixel_i = raw;
    first_frame_i = first;
    do @(posedge clk_i); while (in_stall_o);
    model_pixel(mode, idx, raw, first, typed, typed_res);
  endtask

  // Drop valid for a random gap now and then; bursts run in between.
  task automatic sender_gap();
    int unsigned gap;
    if ($urandom_range(0, 3) != 0) return;
    gap = $urandom_range(1, 8);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (gap - 1) @(negedge clk_i);
  endtask

  // Wait until every expected pixel is back and the pipeline has drained.
  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the register takes the value at its end.
  task automatic write_reg(reg_e r, logic [31:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {r, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (r == RegDarkFrames) dark_frames_m = value[FrmW-1:0];
    else resp_frames_m = value[FrmW-1:0];
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Receiver: stalls at a randomly redrawn density; a long hold-off on request.
  always @(negedge clk_i) begin
    int unsigned density;
    if (cycle_count % 64 == 0) density = $urandom_range(0, 3);
    if (hold_cycles != 0) begin
      out_stall_i = 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      case (density)
        0: out_stall_i = 1'b0;
        1: out_stall_i = ($urandom_range(0, 3) == 0);
        2: out_stall_i = ($urandom_range(0, 1) == 0);
        default: out_stall_i = ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    pixel_result_t want;
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: index %0h corrected %0h", pixel_out_index_o,
               corrected_o);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_out_index_o !== want.idx) begin
          $error("pixel_out_index: expected %0h, got %0h", want.idx, pixel_out_index_o);
          fail_count++;
        end
        if (corrected_o !== want.corr) begin
          $error("corrected: expected %0h, got %0h", want.corr, corrected_o);
          fail_count++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, saturated_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: report a mismatch and stop once cycle_count passes CycleLimit.
  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("flat_field_calibration: mismatch");
      $finish;
    end
  end

  // Directed rows, run under the reset frame counts (Nd 30, Nr 25).
  stim_row_t directed_rows[] = '{
    // empty stores: zero raw gives zero, any positive raw saturates
    '{ModeCorrect, 18'h00000, 16'h0000, 1'b0, 1'b1, 20'h00000, 1'b0},
    '{ModeCorrect, 18'h3FFFF, 16'hFFFF, 1'b1, 1'b1, OutMax, 1'b1},
    // mode three leaves the stores alone
    '{ModeNone, 18'h00000, 16'hFFFF, 1'b1, 1'b0, '0, 1'b0},
    '{ModeCorrect, 18'h00000, 16'h0001, 1'b0, 1'b1, OutMax, 1'b1},
    '{ModeDark, 18'h00005, 16'd1000, 1'b1, 1'b0, '0, 1'b0},
    '{ModeDark, 18'h00005, 16'd1000, 1'b0, 1'b0, '0, 1'b0},
    '{ModeResp, 18'h00005, 16'd40000, 1'b1, 1'b0, '0, 1'b0},
    // raw below the dark average clamps at zero
    '{ModeCorrect, 18'h00005, 16'h0000, 1'b0, 1'b1, 20'h00000, 1'b0},
    '{ModeCorrect, 18'h00005, 16'd20000, 1'b0, 1'b0, '0, 1'b0},
    '{ModeCorrect, 18'h00005, 16'hFFFF, 1'b0, 1'b0, '0, 1'b0},
    // first frame overwrites a sum that was there
    '{ModeResp, 18'h00005, 16'd3000, 1'b1, 1'b0, '0, 1'b0},
    '{ModeCorrect, 18'h00005, 16'd2000, 1'b1, 1'b0, '0, 1'b0},
    // negative den: both signs negative give a positive quotient, else zero
    '{ModeDark, 18'h3FFFF, 16'hFFFF, 1'b1, 1'b0, '0, 1'b0},
    '{ModeResp, 18'h3FFFF, 16'h0000, 1'b1, 1'b0, '0, 1'b0},
    '{ModeCorrect, 18'h3FFFF, 16'h0000, 1'b0, 1'b0, '0, 1'b0},
    '{ModeCorrect, 18'h3FFFF, 16'hFFFF, 1'b0, 1'b1, 20'h00000, 1'b0},
    '{ModeNone, 18'h3FFFF, 16'h0000, 1'b0, 1'b0, '0, 1'b0},
    '{ModeCorrect, 18'h3FFFF, 16'h8000, 1'b0, 1'b0, '0, 1'b0}
  };

  // Frame count settings per phase, extremes included.
  int unsigned dark_settings[] = '{1, 64, 0, 127, 64, 17, 1};
  int unsigned resp_settings[] = '{1, 64, 64, 1, 0, 9, 127};

  initial begin
    int unsigned n;
    mode_e m;
    logic [IdxW-1:0] idx;
    logic [RawW-1:0] raw;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table; typed rows carry their own expectation
    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].mode, directed_rows[i].idx, directed_rows[i].raw,
                 directed_rows[i].first, directed_rows[i].typed,
                 '{directed_rows[i].idx, directed_rows[i].corr, directed_rows[i].sat});
      sender_gap();
    end

    foreach (dark_settings[p]) begin
      // hold the sender until the block is idle, then rewrite the counts
      drain_pipeline();
      write_reg(RegDarkFrames, dark_settings[p]);
      write_reg(RegRespFrames, resp_settings[p]);
      foreach (pixel_pool[k]) pixel_pool[k] = IdxW'($urandom_range(0, MaxPixels - 1));
      if (p == 1) hold_cycles = 400;
      n = 0;
      while (n < PhaseItems) begin
        idx = ($urandom_range(0, 4) == 0) ? IdxW'($urandom) :
              pixel_pool[$urandom_range(0, 7)];
        if ($urandom_range(0, 49) == 0) begin
          // hammer one pixel past the sum limit
          m = ($urandom_range(0, 1) == 0) ? ModeDark : ModeResp;
          repeat (70) send_pixel(m, idx, 16'hFFFF, 1'b0);
          n += 70;
          continue;
        end
        if ($urandom_range(0, 2) == 0) begin
          // well-formed frame set: dark frames, response frames, then correct
          for (int f = 0; f < 3; f++) begin
            send_pixel(ModeDark, idx, RawW'($urandom_range(0, 4000)), f == 0);
            sender_gap();
          end
          for (int f = 0; f < 3; f++) begin
            send_pixel(ModeResp, idx, RawW'($urandom_range(20000, 65535)), f == 0);
            sender_gap();
          end
          send_pixel(ModeCorrect, idx, RawW'($urandom), 1'b0);
          n += 7;
        end else begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: m = ModeDark;
            5, 6, 7, 8, 9: m = ModeResp;
            19: m = ModeNone;
            default: m = ModeCorrect;
          endcase
          raw = RawW'($urandom);
          send_pixel(m, idx, raw, $urandom_range(0, 5) == 0);
          if (m != ModeNone) n++;
        end
        sender_gap();
      end
    end

    drain_pipeline();
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("flat_field_calibration: match");
    end else begin
      $display("flat_field_calibration: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ffc_pkg.sv
rtl/ffc_ram.sv
rtl/ffc_div.sv
rtl/flat_field_calibration.sv
tb/sv/tb_flat_field_calibration.sv
